// ===== rtl/sced_pkg.sv =====
// shared types, constants and the seven-segment code table
// no dependencies; used by every module of the coordinate entry display
`default_nettype none

package sced_pkg;

   localparam int unsigned LimitWidth = 7;
   localparam int unsigned PosWidth   = 8;
   localparam int unsigned SegWidth   = 8;
   localparam int unsigned BtnWidth   = 4;

   localparam logic [LimitWidth-1:0] LIMIT_RESET   = 7'd40;
   localparam logic [LimitWidth-1:0] LIMIT_CEILING = 7'd99;
   localparam logic [SegWidth-1:0]   DP_BIT        = 8'h80;

   // button bit positions
   localparam int unsigned BTN_DOWN  = 0;
   localparam int unsigned BTN_RIGHT = 1;
   localparam int unsigned BTN_LEFT  = 2;
   localparam int unsigned BTN_UP    = 3;

   typedef struct packed {
      logic [SegWidth-1:0] ones;
      logic [SegWidth-1:0] tens;
   } seg_pair_type;

   // active-low segments, decimal point off
   function automatic logic [SegWidth-1:0] seg_code(input logic [3:0] digit);
      logic [SegWidth-1:0] code;
      case (digit)
         4'd0: code = 8'hc0;
         4'd1: code = 8'hf9;
         4'd2: code = 8'ha4;
         4'd3: code = 8'hb0;
         4'd4: code = 8'h99;
         4'd5: code = 8'h92;
         4'd6: code = 8'h82;
         4'd7: code = 8'hf8;
         4'd8: code = 8'h80;
         4'd9: code = 8'h90;
         default: code = 8'hff;
      endcase
      return code;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/sced_axis.sv =====
// one axis position step: raise then lower, each kept within plus or minus the limit
// depends on sced_pkg
`default_nettype none

module sced_axis (
   input  wire logic signed [sced_pkg::PosWidth-1:0]   pos,
   input  wire logic                                   raise,
   input  wire logic                                   lower,
   input  wire logic        [sced_pkg::LimitWidth-1:0] limit,
   output logic signed      [sced_pkg::PosWidth-1:0]   next_pos
);

   logic signed [sced_pkg::PosWidth:0] pos_w;
   logic signed [sced_pkg::PosWidth:0] lim_w;
   logic signed [sced_pkg::PosWidth:0] plus_one;
   logic signed [sced_pkg::PosWidth:0] mid_pos;
   logic signed [sced_pkg::PosWidth:0] minus_one;
   logic signed [sced_pkg::PosWidth:0] final_pos;

   always_comb begin
      pos_w     = {pos[sced_pkg::PosWidth-1], pos};
      lim_w     = $signed({2'b00, limit});
      plus_one  = pos_w + 9'sd1;
      mid_pos   = (raise && (plus_one <= lim_w)) ? plus_one : pos_w;
      minus_one = mid_pos - 9'sd1;
      final_pos = (lower && (minus_one >= -lim_w)) ? minus_one : mid_pos;
      next_pos  = final_pos[sced_pkg::PosWidth-1:0];
   end

endmodule

`default_nettype wire

// ===== rtl/sced_digits.sv =====
// magnitude of a signed position split into tens and ones, coded for the display
// depends on sced_pkg
`default_nettype none

module sced_digits (
   input  wire logic signed [sced_pkg::PosWidth-1:0] pos,
   output sced_pkg::seg_pair_type                    segs
);

   logic [sced_pkg::PosWidth-1:0]   mag_full;
   logic [sced_pkg::LimitWidth-1:0] mag;
   logic [14:0]                     prod;
   logic [3:0]                      tens;
   logic [sced_pkg::LimitWidth-1:0] tens_x10;
   logic [3:0]                      ones;
   logic                            neg;

   always_comb begin
      neg      = pos[sced_pkg::PosWidth-1];
      mag_full = neg ? (~pos + 8'd1) : pos;
      mag      = (mag_full > {1'b0, sced_pkg::LIMIT_CEILING})
                 ? sced_pkg::LIMIT_CEILING : mag_full[sced_pkg::LimitWidth-1:0];
      // divide by ten: exact for values up to 99
      prod     = 15'(mag) * 15'd205;
      tens     = prod[14:11];
      tens_x10 = 7'({tens, 3'b000}) + 7'({tens, 1'b0});
      ones     = 4'(mag - tens_x10);
      segs.ones = sced_pkg::seg_code(ones);
      segs.tens = sced_pkg::seg_code(tens);
      if (neg) begin
         segs.ones = segs.ones & ~sced_pkg::DP_BIT;
         segs.tens = segs.tens & ~sced_pkg::DP_BIT;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/signed_coordinate_entry_display.sv =====
// signed coordinate entry: button edges move x/y positions, shown as segment bytes
// Usage:
//   req channel: one request per sample of the four raw buttons (valid/stall).
//   rsp channel: one result per request with four segment bytes and both
//   signed positions (valid/stall).
//   csr channel: writes the position limit; csr_ready is always high.
//   The input register takes an accepted request, and the update is written
//   into the result register once that register is free to take it.
//   Throughput is one request per cycle while rsp_stall stays low, set by the
//   single update stage that reads and writes the position registers.
//   When rsp_stall is high the result register holds; the input register can
//   still take one more request, then req_stall rises until the result moves.
//   Reset clears both positions and the previous button sample and sets the
//   limit to 40; both channels come out of reset empty.
//   Limits above 99 act as 99. The user must write the limit only while the
//   block is idle; the block itself does not enforce it.
// depends on sced_pkg, sced_axis, sced_digits
`default_nettype none

module signed_coordinate_entry_display (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   req_valid,
   output logic                                        req_stall,
   input  wire logic [sced_pkg::BtnWidth-1:0]          req_buttons,
   output logic                                        rsp_valid,
   input  wire logic                                   rsp_stall,
   output logic [sced_pkg::SegWidth-1:0]               rsp_y_ones_segments,
   output logic [sced_pkg::SegWidth-1:0]               rsp_y_tens_segments,
   output logic [sced_pkg::SegWidth-1:0]               rsp_x_ones_segments,
   output logic [sced_pkg::SegWidth-1:0]               rsp_x_tens_segments,
   output logic signed [sced_pkg::PosWidth-1:0]        rsp_y_value,
   output logic signed [sced_pkg::PosWidth-1:0]        rsp_x_value,
   input  wire logic                                   csr_valid,
   output logic                                        csr_ready,
   input  wire logic [sced_pkg::LimitWidth-1:0]        csr_position_limit
);

   logic [sced_pkg::BtnWidth-1:0]          buttons_ff;
   logic                                   s1_valid_ff;
   logic                                   s1_valid_in;
   logic [sced_pkg::BtnWidth-1:0]          prev_ff;
   logic signed [sced_pkg::PosWidth-1:0]   y_pos_ff;
   logic signed [sced_pkg::PosWidth-1:0]   x_pos_ff;
   logic [sced_pkg::LimitWidth-1:0]        limit_ff;
   logic                                   rsp_valid_ff;
   logic                                   rsp_valid_in;
   sced_pkg::seg_pair_type                 y_segs_ff;
   sced_pkg::seg_pair_type                 x_segs_ff;

   logic                                   req_take;
   logic                                   out_free;
   logic                                   advance;
   logic [sced_pkg::LimitWidth-1:0]        eff_limit;
   logic [sced_pkg::BtnWidth-1:0]          edges;
   logic signed [sced_pkg::PosWidth-1:0]   y_next;
   logic signed [sced_pkg::PosWidth-1:0]   x_next;
   sced_pkg::seg_pair_type                 y_segs;
   sced_pkg::seg_pair_type                 x_segs;

   assign csr_ready = 1'b1;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign advance   = s1_valid_ff && out_free;
   assign req_stall = s1_valid_ff && !out_free;
   assign req_take  = req_valid && !req_stall;

   assign eff_limit = (limit_ff > sced_pkg::LIMIT_CEILING) ? sced_pkg::LIMIT_CEILING : limit_ff;
   assign edges     = buttons_ff & ~prev_ff;

   sced_axis u_axis_y (
      .pos      (y_pos_ff),
      .raise    (edges[sced_pkg::BTN_UP]),
      .lower    (edges[sced_pkg::BTN_DOWN]),
      .limit    (eff_limit),
      .next_pos (y_next)
   );

   sced_axis u_axis_x (
      .pos      (x_pos_ff),
      .raise    (edges[sced_pkg::BTN_LEFT]),
      .lower    (edges[sced_pkg::BTN_RIGHT]),
      .limit    (eff_limit),
      .next_pos (x_next)
   );

   sced_digits u_digits_y (
      .pos  (y_next),
      .segs (y_segs)
   );

   sced_digits u_digits_x (
      .pos  (x_next),
      .segs (x_segs)
   );

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_take) begin
         s1_valid_in = 1'b1;
      end else if (advance) begin
         s1_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         prev_ff      <= '0;
         y_pos_ff     <= '0;
         x_pos_ff     <= '0;
         limit_ff     <= sced_pkg::LIMIT_RESET;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            limit_ff <= csr_position_limit;
         end
         if (advance) begin
            prev_ff  <= buttons_ff;
            y_pos_ff <= y_next;
            x_pos_ff <= x_next;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_take) begin
         buttons_ff <= req_buttons;
      end
      if (advance) begin
         y_segs_ff <= y_segs;
         x_segs_ff <= x_segs;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_y_ones_segments = y_segs_ff.ones;
   assign rsp_y_tens_segments = y_segs_ff.tens;
   assign rsp_x_ones_segments = x_segs_ff.ones;
   assign rsp_x_tens_segments = x_segs_ff.tens;
   assign rsp_y_value         = y_pos_ff;
   assign rsp_x_value         = x_pos_ff;

   // positions never leave the displayable range
   assert property (@(posedge clock) disable iff (reset)
      (y_pos_ff <= 8'sd99) && (y_pos_ff >= -8'sd99) &&
      (x_pos_ff <= 8'sd99) && (x_pos_ff >= -8'sd99))
      else $error("position out of range");

   // input side only stalls while the input register holds a request
   assert property (@(posedge clock) disable iff (reset)
      req_stall |-> s1_valid_ff)
      else $error("stall with empty input register");

   // a request that leaves the input register shows up as a result next cycle
   assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_valid_ff)
      else $error("result lost after update");

   // positions change only on an update
   assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(y_pos_ff) && $stable(x_pos_ff))
      else $error("position changed without an update");

endmodule

`default_nettype wire

// ===== bench/testbench.sv =====
// self-checking bench for signed_coordinate_entry_display: button samples in, readouts out
// predicts untyped readouts from its position model; depends on sced_pkg and the block's rtl
`timescale 1ns / 1ps

module testbench;

   typedef struct packed {
      logic [sced_pkg::SegWidth-1:0]        y_ones;
      logic [sced_pkg::SegWidth-1:0]        y_tens;
      logic [sced_pkg::SegWidth-1:0]        x_ones;
      logic [sced_pkg::SegWidth-1:0]        x_tens;
      logic signed [sced_pkg::PosWidth-1:0] y_value;
      logic signed [sced_pkg::PosWidth-1:0] x_value;
   } readout_type;

   typedef struct packed {
      logic                            wr_limit;
      logic [sced_pkg::LimitWidth-1:0] limit;
      logic [sced_pkg::BtnWidth-1:0]   btn;
      logic                            typed;
      readout_type                     want;
   } step_row_type;

   localparam logic [sced_pkg::BtnWidth-1:0] PRESS_NONE  = '0;
   localparam logic [sced_pkg::BtnWidth-1:0] PRESS_DOWN  = 4'(1 << sced_pkg::BTN_DOWN);
   localparam logic [sced_pkg::BtnWidth-1:0] PRESS_RIGHT = 4'(1 << sced_pkg::BTN_RIGHT);
   localparam logic [sced_pkg::BtnWidth-1:0] PRESS_LEFT  = 4'(1 << sced_pkg::BTN_LEFT);
   localparam logic [sced_pkg::BtnWidth-1:0] PRESS_UP    = 4'(1 << sced_pkg::BTN_UP);
   localparam logic [sced_pkg::BtnWidth-1:0] PRESS_ALL   = '1;
   localparam logic [sced_pkg::BtnWidth-1:0] RAISE_BOTH  = PRESS_UP | PRESS_LEFT;
   localparam logic [sced_pkg::BtnWidth-1:0] LOWER_BOTH  = PRESS_DOWN | PRESS_RIGHT;
   localparam readout_type NO_WANT = '0;
   localparam int DIRECTED_ROWS = 28;
   localparam int PHASES = 9;
   localparam int WATCHDOG_LIMIT = 2000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [sced_pkg::BtnWidth-1:0] req_buttons = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [sced_pkg::SegWidth-1:0] rsp_y_ones_segments;
   logic [sced_pkg::SegWidth-1:0] rsp_y_tens_segments;
   logic [sced_pkg::SegWidth-1:0] rsp_x_ones_segments;
   logic [sced_pkg::SegWidth-1:0] rsp_x_tens_segments;
   logic signed [sced_pkg::PosWidth-1:0] rsp_y_value;
   logic signed [sced_pkg::PosWidth-1:0] rsp_x_value;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [sced_pkg::LimitWidth-1:0] csr_position_limit = '0;

   signed_coordinate_entry_display uut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_buttons         (req_buttons),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_y_ones_segments (rsp_y_ones_segments),
      .rsp_y_tens_segments (rsp_y_tens_segments),
      .rsp_x_ones_segments (rsp_x_ones_segments),
      .rsp_x_tens_segments (rsp_x_tens_segments),
      .rsp_y_value         (rsp_y_value),
      .rsp_x_value         (rsp_x_value),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_position_limit  (csr_position_limit)
   );

   always #5 clock = ~clock;

   // position model
   logic [sced_pkg::SegWidth-1:0] digit_glyph [10] = '{8'hc0, 8'hf9, 8'ha4, 8'hb0, 8'h99,
                                                       8'h92, 8'h82, 8'hf8, 8'h80, 8'h90};
   logic [sced_pkg::LimitWidth-1:0] limit_now = sced_pkg::LIMIT_RESET;
   logic [sced_pkg::BtnWidth-1:0] held_buttons = '0;
   logic signed [sced_pkg::PosWidth-1:0] pos_y = '0;
   logic signed [sced_pkg::PosWidth-1:0] pos_x = '0;
   int y_lowest = 0, y_highest = 0, x_lowest = 0, x_highest = 0;

   readout_type expected_readouts [$];
   int failures = 0;
   int samples_sent = 0;
   int readouts_checked = 0;
   int limit_writes = 0;
   int quiet_cycles = 0;
   int stall_run = 0;
   bit no_idle = 1'b0;

   step_row_type directed_rows [DIRECTED_ROWS] = '{
      '{1'b0, 7'd0, PRESS_NONE, 1'b1, '{8'hc0, 8'hc0, 8'hc0, 8'hc0, 8'sd0, 8'sd0}},
      '{1'b0, 7'd0, PRESS_UP, 1'b1, '{8'hf9, 8'hc0, 8'hc0, 8'hc0, 8'sd1, 8'sd0}},
      // held up does nothing more
      '{1'b0, 7'd0, PRESS_UP, 1'b1, '{8'hf9, 8'hc0, 8'hc0, 8'hc0, 8'sd1, 8'sd0}},
      '{1'b0, 7'd0, PRESS_NONE, 1'b0, NO_WANT},
      '{1'b0, 7'd0, PRESS_DOWN, 1'b1, '{8'hc0, 8'hc0, 8'hc0, 8'hc0, 8'sd0, 8'sd0}},
      '{1'b0, 7'd0, PRESS_NONE, 1'b0, NO_WANT},
      // negative value lights the decimal point on both digits
      '{1'b0, 7'd0, PRESS_DOWN, 1'b1, '{8'h79, 8'h40, 8'hc0, 8'hc0, -8'sd1, 8'sd0}},
      '{1'b0, 7'd0, PRESS_NONE, 1'b0, NO_WANT},
      '{1'b0, 7'd0, PRESS_UP | PRESS_DOWN, 1'b0, NO_WANT},
      '{1'b0, 7'd0, PRESS_RIGHT, 1'b0, NO_WANT},
      '{1'b0, 7'd0, PRESS_LEFT, 1'b0, NO_WANT},
      '{1'b0, 7'd0, PRESS_ALL, 1'b0, NO_WANT},
      '{1'b0, 7'd0, PRESS_NONE, 1'b0, NO_WANT},
      '{1'b0, 7'd0, PRESS_ALL, 1'b0, NO_WANT},
      // zero limit: positions walk back to zero and stay there
      '{1'b1, 7'd0, PRESS_NONE, 1'b0, NO_WANT},
      '{1'b0, 7'd0, PRESS_NONE, 1'b0, NO_WANT},
      '{1'b0, 7'd0, PRESS_ALL, 1'b0, NO_WANT},
      '{1'b0, 7'd0, PRESS_NONE, 1'b0, NO_WANT},
      '{1'b0, 7'd0, PRESS_ALL, 1'b1, '{8'hc0, 8'hc0, 8'hc0, 8'hc0, 8'sd0, 8'sd0}},
      '{1'b1, 7'd1, PRESS_NONE, 1'b0, NO_WANT},
      '{1'b0, 7'd0, PRESS_NONE, 1'b0, NO_WANT},
      '{1'b0, 7'd0, PRESS_UP, 1'b1, '{8'hf9, 8'hc0, 8'hc0, 8'hc0, 8'sd1, 8'sd0}},
      '{1'b0, 7'd0, PRESS_NONE, 1'b0, NO_WANT},
      // saturates at the limit
      '{1'b0, 7'd0, PRESS_UP, 1'b1, '{8'hf9, 8'hc0, 8'hc0, 8'hc0, 8'sd1, 8'sd0}},
      '{1'b0, 7'd0, PRESS_LEFT, 1'b1, '{8'hf9, 8'hc0, 8'hf9, 8'hc0, 8'sd1, 8'sd1}},
      '{1'b0, 7'd0, LOWER_BOTH, 1'b1, '{8'hc0, 8'hc0, 8'hc0, 8'hc0, 8'sd0, 8'sd0}},
      '{1'b1, 7'd127, PRESS_NONE, 1'b0, NO_WANT},
      '{1'b0, 7'd0, RAISE_BOTH, 1'b0, NO_WANT}
   };

   function automatic logic signed [sced_pkg::PosWidth-1:0] nudge(
         input logic signed [sced_pkg::PosWidth-1:0] pos,
         input bit raise, input bit lower, input int bound);
      int p;
      p = pos;
      if (raise && p + 1 <= bound) p = p + 1;
      if (lower && p - 1 >= -bound) p = p - 1;
      return 8'(p);
   endfunction

   function automatic logic [2*sced_pkg::SegWidth-1:0] glyph_pair(
         input logic signed [sced_pkg::PosWidth-1:0] pos);
      int p;
      int mag;
      logic [sced_pkg::SegWidth-1:0] ones;
      logic [sced_pkg::SegWidth-1:0] tens;
      p = pos;
      mag = (p < 0) ? -p : p;
      if (mag > sced_pkg::LIMIT_CEILING) mag = sced_pkg::LIMIT_CEILING;
      ones = digit_glyph[mag % 10];
      tens = digit_glyph[mag / 10];
      if (p < 0) begin
         ones = ones & ~sced_pkg::DP_BIT;
         tens = tens & ~sced_pkg::DP_BIT;
      end
      return {ones, tens};
   endfunction

   function automatic readout_type predict_readout(input logic [sced_pkg::BtnWidth-1:0] btn);
      logic [sced_pkg::BtnWidth-1:0] rising;
      int bound;
      readout_type r;
      rising = btn & ~held_buttons;
      bound = (limit_now > sced_pkg::LIMIT_CEILING) ? sced_pkg::LIMIT_CEILING : limit_now;
      held_buttons = btn;
      pos_y = nudge(pos_y, rising[sced_pkg::BTN_UP], rising[sced_pkg::BTN_DOWN], bound);
      pos_x = nudge(pos_x, rising[sced_pkg::BTN_LEFT], rising[sced_pkg::BTN_RIGHT], bound);
      {r.y_ones, r.y_tens} = glyph_pair(pos_y);
      {r.x_ones, r.x_tens} = glyph_pair(pos_x);
      r.y_value = pos_y;
      r.x_value = pos_x;
      if (pos_y < y_lowest) y_lowest = pos_y;
      if (pos_y > y_highest) y_highest = pos_y;
      if (pos_x < x_lowest) x_lowest = pos_x;
      if (pos_x > x_highest) x_highest = pos_x;
      return r;
   endfunction

   // mostly short, now and then long
   function automatic int idle_length();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return $urandom_range(0, 2);
      if (r < 95) return $urandom_range(3, 8);
      return $urandom_range(15, 40);
   endfunction

   task automatic send_sample(input logic [sced_pkg::BtnWidth-1:0] btn, input bit typed,
         input readout_type want);
      readout_type predicted;
      int gap;
      req_valid <= 1'b1;
      req_buttons <= btn;
      do @(posedge clock); while (req_stall);
      predicted = predict_readout(btn);
      expected_readouts.push_back(typed ? want : predicted);
      samples_sent++;
      gap = (no_idle || $urandom_range(0, 1) == 0) ? 0 : idle_length();
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic finish_outstanding();
      req_valid <= 1'b0;
      while (expected_readouts.size() != 0) @(posedge clock);
   endtask

   task automatic write_limit(input logic [sced_pkg::LimitWidth-1:0] value);
      csr_valid <= 1'b1;
      csr_position_limit <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      limit_now = value;
      limit_writes++;
   endtask

   task automatic check_field(input string name, input logic [sced_pkg::SegWidth-1:0] want,
         input logic [sced_pkg::SegWidth-1:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
         failures++;
      end
   endtask

   always @(posedge clock) begin
      if (no_idle) begin
         rsp_stall <= 1'b0;
         stall_run <= 0;
      end else if (stall_run == 0) begin
         rsp_stall <= ($urandom_range(0, 2) == 0);
         stall_run <= idle_length();
      end else begin
         stall_run <= stall_run - 1;
      end
   end

   always @(posedge clock) begin : check_readouts
      readout_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_readouts.size() == 0) begin
            $display("%0t: readout with no request outstanding, y %0d x %0d",
                     $time, rsp_y_value, rsp_x_value);
            failures++;
         end else begin
            want = expected_readouts.pop_front();
            check_field("y_ones_segments", want.y_ones, rsp_y_ones_segments);
            check_field("y_tens_segments", want.y_tens, rsp_y_tens_segments);
            check_field("x_ones_segments", want.x_ones, rsp_x_ones_segments);
            check_field("x_tens_segments", want.x_tens, rsp_x_tens_segments);
            check_field("y_value", want.y_value, rsp_y_value);
            check_field("x_value", want.x_value, rsp_x_value);
            readouts_checked++;
         end
      end
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (csr_valid && csr_ready))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: watchdog, no handshake for %0d cycles", $time, quiet_cycles);
         $display("Some tests failed");
         $finish;
      end
   end

   initial begin
      int row;
      int p;
      int i;
      int phase_len [PHASES];
      logic [sced_pkg::LimitWidth-1:0] phase_limit [PHASES];
      logic [sced_pkg::LimitWidth-1:0] lim;
      logic [sced_pkg::BtnWidth-1:0] btn;
      logic [sced_pkg::BtnWidth-1:0] favored;
      bit pressed;
      phase_len = '{500, 250, 60, 40, 40, 60, 60, 60, 80};
      phase_limit = '{7'd99, 7'd127, 7'd100, 7'd0, 7'd1, 7'd0, 7'd0, 7'd0, 7'd3};
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (row = 0; row < DIRECTED_ROWS; row++) begin
         if (directed_rows[row].wr_limit) begin
            finish_outstanding();
            write_limit(directed_rows[row].limit);
         end else begin
            send_sample(directed_rows[row].btn, directed_rows[row].typed,
                        directed_rows[row].want);
         end
      end

      // drive both axes to the far ends, then roam under other limits
      for (p = 0; p < PHASES; p++) begin
         finish_outstanding();
         no_idle = (p % 3 == 2);
         lim = (p >= 5 && p <= 7) ? 7'($urandom_range(0, 127)) : phase_limit[p];
         write_limit(lim);
         pressed = 1'b0;
         favored = RAISE_BOTH;
         for (i = 0; i < phase_len[p]; i++) begin
            if (p == 0)
               favored = (i < phase_len[p] / 2) ? RAISE_BOTH : LOWER_BOTH;
            else if (p == 1)
               favored = LOWER_BOTH;
            else if (p == 2)
               favored = RAISE_BOTH;
            else if (i % 20 == 0)
               favored = 4'($urandom_range(1, 15));
            if ($urandom_range(0, 9) == 0) begin
               btn = 4'($urandom_range(0, 15));
            end else if (!pressed) begin
               btn = favored | (($urandom_range(0, 7) == 0) ? 4'($urandom_range(0, 15)) : '0);
               pressed = 1'b1;
            end else begin
               btn = ($urandom_range(0, 7) == 0) ? (favored & 4'($urandom_range(0, 15))) : '0;
               pressed = 1'b0;
            end
            send_sample(btn, 1'b0, NO_WANT);
         end
      end

      finish_outstanding();
      repeat (6) @(posedge clock);
      if (expected_readouts.size() != 0) begin
         $display("%0t: %0d readouts never arrived", $time, expected_readouts.size());
         failures++;
      end
      $display("covered %0d button samples under %0d limit writes, %0d readouts compared",
               samples_sent, limit_writes, readouts_checked);
      $display("y spanned %0d to %0d, x spanned %0d to %0d",
               y_lowest, y_highest, x_lowest, x_highest);
      if (failures == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule
